### design/ebcs_pkg.sv
// ---------------------------------------------------------------------------
// ebcs_pkg
// Shared widths, datapath operation codes and the command and status words
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package ebcs_pkg;

  localparam int MAX_BALLS = 16;
  localparam int IDX_W     = $clog2(MAX_BALLS);
  localparam int CNT_W     = $clog2(MAX_BALLS + 1);
  localparam int POS_W     = 18;
  localparam int VEL_W     = 16;
  localparam int DIV_W     = 48;
  localparam int DEN_W     = 28;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_TICK     = 5'd2;
  localparam op_t OP_RD       = 5'd3;
  localparam op_t OP_TAKE_I   = 5'd4;
  localparam op_t OP_TAKE_J   = 5'd5;
  localparam op_t OP_DIFF     = 5'd6;
  localparam op_t OP_SQ       = 5'd7;
  localparam op_t OP_D2       = 5'd8;
  localparam op_t OP_DOT1     = 5'd9;
  localparam op_t OP_DOT2     = 5'd10;
  localparam op_t OP_NUM_X    = 5'd11;
  localparam op_t OP_NUM_Y    = 5'd12;
  localparam op_t OP_PNUM_X   = 5'd13;
  localparam op_t OP_PNUM_Y   = 5'd14;
  localparam op_t OP_DIV_D2   = 5'd15;
  localparam op_t OP_DIV_DIST = 5'd16;
  localparam op_t OP_CX       = 5'd17;
  localparam op_t OP_CY       = 5'd18;
  localparam op_t OP_PX       = 5'd19;
  localparam op_t OP_PY       = 5'd20;
  localparam op_t OP_VEL      = 5'd21;
  localparam op_t OP_ADV_PAIR = 5'd22;
  localparam op_t OP_SQRT     = 5'd23;
  localparam op_t OP_OV       = 5'd24;
  localparam op_t OP_PUSH     = 5'd25;
  localparam op_t OP_WR_J     = 5'd26;
  localparam op_t OP_WALL     = 5'd27;
  localparam op_t OP_ADV_I    = 5'd28;
  localparam op_t OP_EMIT     = 5'd29;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic             div_busy;
    logic             sq_busy;
    logic             out_free;
    logic [CNT_W-1:0] n_eff;
  } sts_t;

endpackage

### design/elastic_ball_collision_step_unit.sv
// ---------------------------------------------------------------------------
// elastic_ball_collision_step_unit
// Equal-mass elastic collision step for a box of balls: load words fill the
// ball store, a tick word walks all pairs and emits every ball's position.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  load or tick item
//   out_     output     out_valid/out_stall one ball position per word
//   cfg_     input      cfg_we             radius, box size, ball count
//
// A load word is taken while idle. A pair that touches uses the 48-step
// divider four times. Reset sets the registers; the ball store holds nothing
// until loaded. A stalled result word holds the walk at that ball; a new input
// word is taken only once the tick is done.
// ---------------------------------------------------------------------------
module elastic_ball_collision_step_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [12:0]                       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [3:0]                        in_ball_index,
  input  logic signed [ebcs_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ebcs_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ebcs_pkg::VEL_W-1:0] in_vel_x,
  input  logic signed [ebcs_pkg::VEL_W-1:0] in_vel_y,
  input  logic [7:0]                        in_elapsed_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_ball_number,
  output logic signed [ebcs_pkg::POS_W-1:0] out_new_x,
  output logic signed [ebcs_pkg::POS_W-1:0] out_new_y,
  output logic                              out_last
);
  import ebcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ebcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebcs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_ball_index   (in_ball_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ball_number (out_ball_number),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> (cmd.op != OP_DIV_D2 && cmd.op != OP_DIV_DIST))
    else $error("Divider restarted while busy.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> sts.out_free)
    else $error("Result word overwritten before it was taken.");

  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sts.sq_busy) |-> ($past(cmd.op) == OP_SQRT))
    else $error("Square-root unit started without a command.");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD || cmd.op == OP_TICK) |-> !in_stall)
    else $error("Input word taken while a tick is running.");
`endif

endmodule

### design/ebcs_div.sv
// ---------------------------------------------------------------------------
// ebcs_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero.
// ---------------------------------------------------------------------------
module ebcs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ebcs_pkg::DIV_W-1:0] num,
  input  logic        [ebcs_pkg::DEN_W-1:0] den,
  output logic                              busy,
  output logic signed [ebcs_pkg::DIV_W-1:0] quo
);
  import ebcs_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] a_r, a_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r, busy_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial   = {rem_r, a_r[DIV_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  assign a_nxt   = {a_r[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DIV_W-1];
      a_r   <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? $signed(-a_r) : $signed(a_r);

endmodule

### design/ebcs_dp.sv
// ---------------------------------------------------------------------------
// ebcs_dp
// Datapath: configuration registers, ball store, working registers for the
// two balls of a pair, square-root unit, divider and the result register.
// ---------------------------------------------------------------------------
module ebcs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ebcs_pkg::cmd_t                    cmd,
  output ebcs_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [12:0]                       cfg_wdata,
  input  logic [3:0]                        in_ball_index,
  input  logic signed [ebcs_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ebcs_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ebcs_pkg::VEL_W-1:0] in_vel_x,
  input  logic signed [ebcs_pkg::VEL_W-1:0] in_vel_y,
  input  logic [7:0]                        in_elapsed_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_ball_number,
  output logic signed [ebcs_pkg::POS_W-1:0] out_new_x,
  output logic signed [ebcs_pkg::POS_W-1:0] out_new_y,
  output logic                              out_last
);
  import ebcs_pkg::*;

  function automatic logic signed [VEL_W-1:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return 16'sh8000;
    return v[VEL_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat18(input logic signed [20:0] v);
    if (v > 21'sd131071) return 18'sh1ffff;
    if (v < -21'sd131072) return 18'sh20000;
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] neg16(input logic signed [VEL_W-1:0] v);
    if (v == 16'sh8000) return 16'sh7fff;
    return -v;
  endfunction

  function automatic logic signed [POS_W-1:0] adv(input logic signed [POS_W-1:0] p,
                                                  input logic signed [VEL_W-1:0] v,
                                                  input logic [7:0] t);
    logic signed [24:0] prod;
    logic signed [18:0] sh;
    prod = v * $signed({1'b0, t});
    sh   = 19'(prod >>> 6);
    return sat18(21'(p) + 21'(sh));
  endfunction

  logic [12:0]      radius_r;
  logic [10:0]      bw_r, bh_r;
  logic [4:0]       cnt_r;
  logic [7:0]       t_r;
  logic [13:0]      diam_r;
  logic [27:0]      diam2_r;

  logic signed [POS_W-1:0] mem_px [MAX_BALLS];
  logic signed [POS_W-1:0] mem_py [MAX_BALLS];
  logic signed [VEL_W-1:0] mem_vx [MAX_BALLS];
  logic signed [VEL_W-1:0] mem_vy [MAX_BALLS];

  logic signed [POS_W-1:0] rd_px, rd_py, pix, piy, pjx, pjy;
  logic signed [VEL_W-1:0] rd_vx, rd_vy, vix, viy, vjx, vjy;
  logic signed [18:0]      dx_r, dy_r;
  logic signed [16:0]      dvx_r, dvy_r;
  logic signed [37:0]      sqx_r, sqy_r;
  logic [37:0]             d2_r;
  logic                    hit_r;
  logic signed [31:0]      mx_r, my_r;
  logic signed [32:0]      dot_r;
  logic signed [DIV_W-1:0] num_r;
  logic signed [19:0]      cx_r, cy_r, pushx_r, pushy_r;
  logic signed [14:0]      ov_r;
  logic signed [14:0]      dxs, dys;
  logic [13:0]             sq_r, trial;
  logic [3:0]              sq_k_r;
  logic                    sq_busy_r;
  logic                    out_valid_r;

  logic                    div_start, div_busy;
  logic [DEN_W-1:0]        div_den;
  logic signed [DIV_W-1:0] quo;

  logic signed [POS_W-1:0] wx, wy;
  logic signed [VEL_W-1:0] wvx, wvy;
  logic [16:0]             right, bottom;

  assign dxs = dx_r[14:0];
  assign dys = dy_r[14:0];

  assign div_start = (cmd.op == OP_DIV_D2) || (cmd.op == OP_DIV_DIST);
  assign div_den   = (cmd.op == OP_DIV_D2) ? d2_r[DEN_W-1:0] : {14'd0, sq_r};

  ebcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 13'd640;
      bw_r     <= 11'd500;
      bh_r     <= 11'd500;
      cnt_r    <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_WIDTH:  bw_r     <= cfg_wdata[10:0];
        REG_HEIGHT: bh_r     <= cfg_wdata[10:0];
        REG_COUNT:  cnt_r    <= cfg_wdata[4:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mem_px[in_ball_index] <= in_pos_x;
        mem_py[in_ball_index] <= in_pos_y;
        mem_vx[in_ball_index] <= in_vel_x;
        mem_vy[in_ball_index] <= in_vel_y;
      end
      OP_WR_J: begin
        mem_px[cmd.addr] <= pjx;
        mem_py[cmd.addr] <= pjy;
        mem_vx[cmd.addr] <= vjx;
        mem_vy[cmd.addr] <= vjy;
      end
      OP_EMIT: begin
        mem_px[cmd.addr] <= pix;
        mem_py[cmd.addr] <= piy;
        mem_vx[cmd.addr] <= vix;
        mem_vy[cmd.addr] <= viy;
      end
      default: ;
    endcase
    if (cmd.op == OP_RD) begin
      rd_px <= mem_px[cmd.addr];
      rd_py <= mem_py[cmd.addr];
      rd_vx <= mem_vx[cmd.addr];
      rd_vy <= mem_vy[cmd.addr];
    end
  end

  assign right  = {bw_r, 6'd0};
  assign bottom = {bh_r, 6'd0};

  always_comb begin
    wx  = pix;
    wy  = piy;
    wvx = vix;
    wvy = viy;
    if (wx < 0) begin
      wx  = '0;
      wvx = neg16(wvx);
    end
    if (20'(wx) + $signed({6'd0, diam_r}) > $signed({3'd0, right})) begin
      wx  = sat18($signed({4'd0, right}) - $signed({7'd0, diam_r}));
      wvx = neg16(wvx);
    end
    if (wy < 0) begin
      wy  = '0;
      wvy = neg16(wvy);
    end
    if (20'(wy) + $signed({6'd0, diam_r}) > $signed({3'd0, bottom})) begin
      wy  = sat18($signed({4'd0, bottom}) - $signed({7'd0, diam_r}));
      wvy = neg16(wvy);
    end
  end

  assign trial = sq_r | (14'd1 << sq_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.op == OP_SQRT) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_k_r == 4'd0) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT) begin
      sq_r   <= '0;
      sq_k_r <= 4'd13;
    end else if (sq_busy_r) begin
      if (28'(trial * trial) <= d2_r[27:0]) sq_r <= trial;
      sq_k_r <= sq_k_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TICK: begin
        t_r     <= in_elapsed_ms;
        diam_r  <= {radius_r, 1'b0};
        diam2_r <= {26'(radius_r * radius_r), 2'b00};
      end
      OP_TAKE_I: begin
        pix <= rd_px;
        piy <= rd_py;
        vix <= rd_vx;
        viy <= rd_vy;
      end
      OP_TAKE_J: begin
        pjx <= rd_px;
        pjy <= rd_py;
        vjx <= rd_vx;
        vjy <= rd_vy;
      end
      OP_DIFF: begin
        dx_r  <= 19'(pjx) - 19'(pix);
        dy_r  <= 19'(pjy) - 19'(piy);
        dvx_r <= 17'(vjx) - 17'(vix);
        dvy_r <= 17'(vjy) - 17'(viy);
      end
      OP_SQ: begin
        sqx_r <= dx_r * dx_r;
        sqy_r <= dy_r * dy_r;
      end
      OP_D2: d2_r <= $unsigned(sqx_r) + $unsigned(sqy_r);
      OP_DOT1: begin
        mx_r <= dvx_r * dxs;
        my_r <= dvy_r * dys;
      end
      OP_DOT2:   dot_r <= 33'(mx_r) + 33'(my_r);
      OP_NUM_X:  num_r <= dot_r * dxs;
      OP_NUM_Y:  num_r <= dot_r * dys;
      OP_PNUM_X: num_r <= ov_r * dxs;
      OP_PNUM_Y: num_r <= ov_r * dys;
      OP_CX:     cx_r <= quo[19:0];
      OP_CY:     cy_r <= quo[19:0];
      OP_PX:     pushx_r <= quo[19:0];
      OP_PY:     pushy_r <= quo[19:0];
      OP_VEL: begin
        vjx <= sat16(21'(vjx) - 21'(cx_r));
        vjy <= sat16(21'(vjy) - 21'(cy_r));
        vix <= sat16(21'(vix) + 21'(cx_r));
        viy <= sat16(21'(viy) + 21'(cy_r));
      end
      OP_ADV_PAIR: begin
        pjx <= adv(pjx, vjx, t_r);
        pjy <= adv(pjy, vjy, t_r);
        pix <= adv(pix, vix, t_r);
        piy <= adv(piy, viy, t_r);
      end
      OP_OV: ov_r <= $signed({1'b0, diam_r} - {1'b0, sq_r});
      OP_PUSH: begin
        pjx <= sat18(21'(pjx) + 21'(pushx_r));
        pjy <= sat18(21'(pjy) + 21'(pushy_r));
        pix <= sat18(21'(pix) - 21'(pushx_r));
        piy <= sat18(21'(piy) - 21'(pushy_r));
      end
      OP_WALL: begin
        pix <= wx;
        piy <= wy;
        vix <= wvx;
        viy <= wvy;
      end
      OP_ADV_I: begin
        pix <= adv(pix, vix, t_r);
        piy <= adv(piy, viy, t_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.op == OP_D2) begin
      hit_r <= ($unsigned(sqx_r) + $unsigned(sqy_r) != 38'd0) &&
               (38'($unsigned(sqx_r) + $unsigned(sqy_r)) < {10'd0, diam2_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_ball_number <= cmd.addr;
      out_new_x       <= pix;
      out_new_y       <= piy;
      out_last        <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.hit      = hit_r;
  assign sts.div_busy = div_busy;
  assign sts.sq_busy  = sq_busy_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.n_eff    = (cnt_r > CNT_W'(MAX_BALLS)) ? CNT_W'(MAX_BALLS) : cnt_r;

endmodule

### design/ebcs_ctrl.sv
// ---------------------------------------------------------------------------
// ebcs_ctrl
// Controller: walks the balls and pairs of a tick and issues at most one
// datapath operation per cycle; it waits while a unit or output is busy.
// ---------------------------------------------------------------------------
module ebcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_stall,
  input  ebcs_pkg::sts_t sts,
  output ebcs_pkg::cmd_t cmd
);
  import ebcs_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_RDI  = 6'd1,  S_TKI  = 6'd2,  S_RDJ  = 6'd3;
  localparam logic [5:0] S_TKJ  = 6'd4,  S_DIFF = 6'd5,  S_SQ   = 6'd6,  S_D2   = 6'd7;
  localparam logic [5:0] S_TEST = 6'd8,  S_DOT1 = 6'd9,  S_DOT2 = 6'd10, S_NUMX = 6'd11;
  localparam logic [5:0] S_DXS  = 6'd12, S_DXW  = 6'd13, S_CX   = 6'd14, S_NUMY = 6'd15;
  localparam logic [5:0] S_DYS  = 6'd16, S_DYW  = 6'd17, S_CY   = 6'd18, S_VEL  = 6'd19;
  localparam logic [5:0] S_ADVP = 6'd20, S_SQS  = 6'd21, S_SQW  = 6'd22, S_OV   = 6'd23;
  localparam logic [5:0] S_PNX  = 6'd24, S_PXS  = 6'd25, S_PXW  = 6'd26, S_PX   = 6'd27;
  localparam logic [5:0] S_PNY  = 6'd28, S_PYS  = 6'd29, S_PYW  = 6'd30, S_PY   = 6'd31;
  localparam logic [5:0] S_PUSH = 6'd32, S_WRJ  = 6'd33, S_WALL = 6'd34, S_ADVI = 6'd35;
  localparam logic [5:0] S_EMIT = 6'd36;

  logic [5:0]       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             i_more, j_more;

  assign i_more = (i_r + CNT_W'(1)) < sts.n_eff;
  assign j_more = (j_r + CNT_W'(1)) < sts.n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd.op    = OP_NOP;
    cmd.addr  = i_r[IDX_W-1:0];
    cmd.last  = !i_more;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.op = OP_TICK;
            i_nxt  = '0;
            if (sts.n_eff != '0) state_nxt = S_RDI;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_RDI: begin
        cmd.op    = OP_RD;
        state_nxt = S_TKI;
      end
      S_TKI: begin
        cmd.op = OP_TAKE_I;
        j_nxt  = i_r + CNT_W'(1);
        state_nxt = i_more ? S_RDJ : S_WALL;
      end
      S_RDJ: begin
        cmd.op    = OP_RD;
        cmd.addr  = j_r[IDX_W-1:0];
        state_nxt = S_TKJ;
      end
      S_TKJ:  begin cmd.op = OP_TAKE_J; state_nxt = S_DIFF; end
      S_DIFF: begin cmd.op = OP_DIFF;   state_nxt = S_SQ;   end
      S_SQ:   begin cmd.op = OP_SQ;     state_nxt = S_D2;   end
      S_D2:   begin cmd.op = OP_D2;     state_nxt = S_TEST; end
      S_TEST: begin
        if (sts.hit) begin
          state_nxt = S_DOT1;
        end else if (j_more) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_WALL;
        end
      end
      S_DOT1: begin cmd.op = OP_DOT1;   state_nxt = S_DOT2; end
      S_DOT2: begin cmd.op = OP_DOT2;   state_nxt = S_NUMX; end
      S_NUMX: begin cmd.op = OP_NUM_X;  state_nxt = S_DXS;  end
      S_DXS:  begin cmd.op = OP_DIV_D2; state_nxt = S_DXW;  end
      S_DXW:  if (!sts.div_busy) state_nxt = S_CX;
      S_CX:   begin cmd.op = OP_CX;     state_nxt = S_NUMY; end
      S_NUMY: begin cmd.op = OP_NUM_Y;  state_nxt = S_DYS;  end
      S_DYS:  begin cmd.op = OP_DIV_D2; state_nxt = S_DYW;  end
      S_DYW:  if (!sts.div_busy) state_nxt = S_CY;
      S_CY:   begin cmd.op = OP_CY;     state_nxt = S_VEL;  end
      S_VEL:  begin cmd.op = OP_VEL;    state_nxt = S_ADVP; end
      S_ADVP: begin cmd.op = OP_ADV_PAIR; state_nxt = S_SQS; end
      S_SQS:  begin cmd.op = OP_SQRT;   state_nxt = S_SQW;  end
      S_SQW:  if (!sts.sq_busy) state_nxt = S_OV;
      S_OV:   begin cmd.op = OP_OV;     state_nxt = S_PNX;  end
      S_PNX:  begin cmd.op = OP_PNUM_X; state_nxt = S_PXS;  end
      S_PXS:  begin cmd.op = OP_DIV_DIST; state_nxt = S_PXW; end
      S_PXW:  if (!sts.div_busy) state_nxt = S_PX;
      S_PX:   begin cmd.op = OP_PX;     state_nxt = S_PNY;  end
      S_PNY:  begin cmd.op = OP_PNUM_Y; state_nxt = S_PYS;  end
      S_PYS:  begin cmd.op = OP_DIV_DIST; state_nxt = S_PYW; end
      S_PYW:  if (!sts.div_busy) state_nxt = S_PY;
      S_PY:   begin cmd.op = OP_PY;     state_nxt = S_PUSH; end
      S_PUSH: begin cmd.op = OP_PUSH;   state_nxt = S_WRJ;  end
      S_WRJ: begin
        cmd.op   = OP_WR_J;
        cmd.addr = j_r[IDX_W-1:0];
        if (j_more) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_WALL;
        end
      end
      S_WALL: begin cmd.op = OP_WALL;   state_nxt = S_ADVI; end
      S_ADVI: begin cmd.op = OP_ADV_I;  state_nxt = S_EMIT; end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op = OP_EMIT;
          if (i_more) begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_RDI;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### tb/tb_elastic_ball_collision_step_unit.sv
// ---------------------------------------------------------------------------
// tb_elastic_ball_collision_step_unit
// Self-checking bench for the ball collision step unit: load and tick words
// go in through a stalling handshake, and every emitted ball position is
// compared with a bit-accurate physics predictor held in the bench. A short
// directed table of corner cases runs first, then random words under a
// sequence of register settings that includes the extremes.
// ---------------------------------------------------------------------------
module tb_elastic_ball_collision_step_unit;
  import ebcs_pkg::*;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TICK} row_kind_t;

  typedef struct {
    logic [3:0]         ball;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               last;
  } ball_pos_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [12:0]        reg_val;
    logic [3:0]         slot;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [7:0]         ms;
    bit                 typed;
    ball_pos_t          typed_pos;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_RADIUS;
  logic [12:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = ACT_LOAD;
  logic [3:0]         in_ball_index = '0;
  logic signed [17:0] in_pos_x = '0;
  logic signed [17:0] in_pos_y = '0;
  logic signed [15:0] in_vel_x = '0;
  logic signed [15:0] in_vel_y = '0;
  logic [7:0]         in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_ball_number;
  logic signed [17:0] out_new_x;
  logic signed [17:0] out_new_y;
  logic               out_last;

  elastic_ball_collision_step_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_ball_index(in_ball_index), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_elapsed_ms(in_elapsed_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ball_number(out_ball_number), .out_new_x(out_new_x),
    .out_new_y(out_new_y), .out_last(out_last)
  );

  // Predictor state: ball store and register copies.
  logic signed [17:0] ball_x [16];
  logic signed [17:0] ball_y [16];
  logic signed [15:0] ball_vx [16];
  logic signed [15:0] ball_vy [16];
  logic [12:0]        radius_q6 = 13'd640;
  logic [10:0]        width_px = 11'd500;
  logic [10:0]        height_px = 11'd500;
  logic [4:0]         count_reg = 5'd16;

  ball_pos_t pending_pos[$];
  int        mismatches = 0;
  longint    cycles = 0;
  bit        quiet = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 9);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ball_pos_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pos.size() == 0) begin
        report_mismatch("unexpected word, ball", out_ball_number, -1);
      end else begin
        want = pending_pos.pop_front();
        if (out_ball_number !== want.ball) report_mismatch("ball", out_ball_number, want.ball);
        if (out_new_x !== want.x) report_mismatch("new_x", out_new_x, want.x);
        if (out_new_y !== want.y) report_mismatch("new_y", out_new_y, want.y);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  function automatic longint sat(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint floor_q6(longint v);
    if (v >= 0) return v / 64;
    return -((-v + 63) / 64);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic void move_ball(int k, longint t);
    ball_x[k] = sat(longint'(ball_x[k]) + floor_q6(longint'(ball_vx[k]) * t), 18);
    ball_y[k] = sat(longint'(ball_y[k]) + floor_q6(longint'(ball_vy[k]) * t), 18);
  endfunction

  function automatic void collide_pair(int i, int j, longint diam, longint t);
    longint dx, dy, d2, dot, cx, cy, root_d, ov;
    dx = longint'(ball_x[j]) - longint'(ball_x[i]);
    dy = longint'(ball_y[j]) - longint'(ball_y[i]);
    d2 = dx * dx + dy * dy;
    if (d2 == 0 || d2 >= diam * diam) return;
    dot = (longint'(ball_vx[j]) - longint'(ball_vx[i])) * dx
        + (longint'(ball_vy[j]) - longint'(ball_vy[i])) * dy;
    cx = dot * dx / d2;
    cy = dot * dy / d2;
    ball_vx[j] = sat(longint'(ball_vx[j]) - cx, 16);
    ball_vy[j] = sat(longint'(ball_vy[j]) - cy, 16);
    ball_vx[i] = sat(longint'(ball_vx[i]) + cx, 16);
    ball_vy[i] = sat(longint'(ball_vy[i]) + cy, 16);
    move_ball(j, t);
    move_ball(i, t);
    root_d = int_sqrt(d2);
    ov = diam - root_d;
    cx = ov * dx / root_d;
    cy = ov * dy / root_d;
    ball_x[j] = sat(longint'(ball_x[j]) + cx, 18);
    ball_y[j] = sat(longint'(ball_y[j]) + cy, 18);
    ball_x[i] = sat(longint'(ball_x[i]) - cx, 18);
    ball_y[i] = sat(longint'(ball_y[i]) - cy, 18);
  endfunction

  function automatic void bounce_walls(int i, longint diam);
    longint right, bottom;
    right = longint'(width_px) * 64;
    bottom = longint'(height_px) * 64;
    if (ball_x[i] < 0) begin
      ball_x[i] = 0;
      ball_vx[i] = sat(-longint'(ball_vx[i]), 16);
    end
    if (longint'(ball_x[i]) + diam > right) begin
      ball_x[i] = sat(right - diam, 18);
      ball_vx[i] = sat(-longint'(ball_vx[i]), 16);
    end
    if (ball_y[i] < 0) begin
      ball_y[i] = 0;
      ball_vy[i] = sat(-longint'(ball_vy[i]), 16);
    end
    if (longint'(ball_y[i]) + diam > bottom) begin
      ball_y[i] = sat(bottom - diam, 18);
      ball_vy[i] = sat(-longint'(ball_vy[i]), 16);
    end
  endfunction

  function automatic void predict_word(stim_row_t r);
    int n;
    longint diam;
    ball_pos_t p;
    if (r.kind == ROW_LOAD) begin
      ball_x[r.slot] = r.px;
      ball_y[r.slot] = r.py;
      ball_vx[r.slot] = r.vx;
      ball_vy[r.slot] = r.vy;
      return;
    end
    n = (count_reg > MAX_BALLS) ? MAX_BALLS : count_reg;
    diam = 2 * longint'(radius_q6);
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) collide_pair(i, j, diam, r.ms);
      bounce_walls(i, diam);
      move_ball(i, r.ms);
      p.ball = i;
      p.x = ball_x[i];
      p.y = ball_y[i];
      p.last = (i + 1 == n);
      if (r.typed) pending_pos = {pending_pos, r.typed_pos};
      else pending_pos = {pending_pos, p};
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    in_valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIUS: radius_q6 = val;
      REG_WIDTH:  width_px = val[10:0];
      REG_HEIGHT: height_px = val[10:0];
      default:    count_reg = val[4:0];
    endcase
  endtask

  task automatic send_word(stim_row_t r);
    if (r.kind == ROW_CFG) begin
      write_reg(r.reg_idx, r.reg_val);
      return;
    end
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= (r.kind == ROW_TICK) ? ACT_TICK : ACT_LOAD;
    in_ball_index <= r.slot;
    in_pos_x <= r.px;
    in_pos_y <= r.py;
    in_vel_x <= r.vx;
    in_vel_y <= r.vy;
    in_elapsed_ms <= r.ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(r);
  endtask

  function automatic stim_row_t make_row(row_kind_t k, logic [3:0] slot, longint px, longint py,
                                         longint vx, longint vy, logic [7:0] ms);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind = k;
    r.slot = slot;
    r.px = px;
    r.py = py;
    r.vx = vx;
    r.vy = vy;
    r.ms = ms;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [12:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t random_load();
    longint px, py, vx, vy;
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) begin
      px = 3000 + $urandom_range(0, 6000) - 3000;
      py = 3000 + $urandom_range(0, 6000) - 3000;
    end else if (m < 8) begin
      px = $urandom_range(0, width_px * 64);
      py = $urandom_range(0, height_px * 64);
    end else begin
      px = $signed(18'($urandom));
      py = $signed(18'($urandom));
    end
    if ($urandom_range(0, 9) < 7) begin
      vx = $urandom_range(0, 4095) - 2048;
      vy = $urandom_range(0, 4095) - 2048;
    end else begin
      vx = $signed(16'($urandom));
      vy = $signed(16'($urandom));
    end
    return make_row(ROW_LOAD, $urandom_range(0, 15), px, py, vx, vy, $urandom);
  endfunction

  initial begin
    stim_row_t table_rows[$];
    stim_row_t r;
    int pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every slot is written before any tick reads the store.
    for (int k = 0; k < MAX_BALLS; k++) begin
      send_word(make_row(ROW_LOAD, k, 2000 * k + 100, 1500 * k + 100, 64 * k - 512, 300 - 40 * k, 0));
    end

    table_rows = {table_rows, cfg_row(REG_COUNT, 5'd1)};
    table_rows = {table_rows, make_row(ROW_LOAD, 0, 64, 64, 0, 0, 0)};
    r = make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd0);
    r.typed = 1'b1;
    r.typed_pos = '{ball: 4'd0, x: 18'sd64, y: 18'sd64, last: 1'b1};
    table_rows = {table_rows, r};
    table_rows = {table_rows, make_row(ROW_LOAD, 15, -131072, 131071, -32768, 32767, 8'hFF)};
    table_rows = {table_rows, make_row(ROW_LOAD, 0, 131071, -131072, 32767, -32768, 0)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd255)};
    table_rows = {table_rows, cfg_row(REG_COUNT, 5'd0)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd7)};
    table_rows = {table_rows, make_row(ROW_LOAD, 1, 5000, 5000, 1000, 0, 0)};
    table_rows = {table_rows, make_row(ROW_LOAD, 0, 5000, 5000, -1000, 0, 0)};
    table_rows = {table_rows, cfg_row(REG_COUNT, 5'd2)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd0)};
    table_rows = {table_rows, cfg_row(REG_COUNT, 5'd31)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd255)};
    table_rows = {table_rows, cfg_row(REG_RADIUS, 13'd8191)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd3)};
    table_rows = {table_rows, cfg_row(REG_RADIUS, 13'd0)};
    table_rows = {table_rows, cfg_row(REG_WIDTH, 13'd1)};
    table_rows = {table_rows, cfg_row(REG_HEIGHT, 13'd1)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd1)};
    table_rows = {table_rows, cfg_row(REG_RADIUS, 13'd640)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd2)};
    table_rows = {table_rows, cfg_row(REG_WIDTH, 13'd2047)};
    table_rows = {table_rows, cfg_row(REG_HEIGHT, 13'd2047)};
    table_rows = {table_rows, make_row(ROW_TICK, 0, 0, 0, 0, 0, 8'd128)};
    foreach (table_rows[n]) send_word(table_rows[n]);

    for (int n = 0; n < 120; n++) begin
      quiet = (n >= 40 && n < 65);
      if (n % 30 == 29) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: write_reg(REG_RADIUS, ($urandom_range(0, 4) == 0) ? 13'd8191 : $urandom_range(0, 1280));
          1: write_reg(REG_WIDTH, ($urandom_range(0, 3) == 0) ? 13'd1 : $urandom_range(1, 2047));
          2: write_reg(REG_HEIGHT, ($urandom_range(0, 3) == 0) ? 13'd2047 : $urandom_range(1, 2047));
          default: write_reg(REG_COUNT, $urandom_range(0, 31));
        endcase
      end
      if ($urandom_range(0, 9) < 7) begin
        send_word(random_load());
      end else begin
        send_word(make_row(ROW_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 20)));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending_pos.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
